>>> rtl/core/lps_pkg.sv
// Package for the layered phase sequencer: phase, action and register codes,
// bus offsets and the structs that pass between the sequencer's modules.
// Depends on nothing; every other file of the block refers to it by scoped names.
package lps_pkg;

   // Widths of the fields and of the state.
   localparam int unsigned ADDR_W   = 64;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned LAYER_W  = 8;
   localparam int unsigned RUNS_W   = 16;
   localparam int unsigned ILEN_W   = 16;
   localparam int unsigned SEQ_W    = 31;
   localparam int unsigned PHASE_W  = 5;
   localparam int unsigned CSR_IDX_W = 3;

   // Register offsets relative to the intercept base.
   localparam logic [ADDR_W-1:0] PHASE_OFFSET   = 64'h0000;
   localparam logic [ADDR_W-1:0] ADVANCE_OFFSET = 64'h0004;
   localparam logic [ADDR_W-1:0] LENGTH_OFFSET  = 64'h0008;

   // Saturation limits.
   localparam logic [LAYER_W-1:0] LAYER_MAX = '1;
   localparam logic [RUNS_W-1:0]  RUNS_MAX  = '1;
   localparam logic [SEQ_W-1:0]   SEQ_MAX   = '1;

   // Value returned once when the exit flag is pending.
   localparam logic [DATA_W-1:0] EXIT_WORD = '1;

   // Reset values of the configuration registers.
   localparam logic [ADDR_W-1:0]  BASE_RESET     = 64'd0;
   localparam logic [LAYER_W-1:0] VISION_RESET   = 8'd24;
   localparam logic [LAYER_W-1:0] LANGUAGE_RESET = 8'd32;
   localparam logic [RUNS_W-1:0]  MAX_RUNS_RESET = 16'd1;
   localparam logic [ILEN_W-1:0]  INIT_LEN_RESET = 16'd228;

   typedef enum logic [1:0] {
      ACT_SHARED_READ = 2'd0,
      ACT_WRITE       = 2'd1,
      ACT_EXCL_READ   = 2'd2,
      ACT_OTHER       = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INTERCEPT_BASE  = 3'd0,
      CSR_VISION_LAYERS   = 3'd1,
      CSR_LANGUAGE_LAYERS = 3'd2,
      CSR_MAX_RUNS        = 3'd3,
      CSR_INITIAL_LENGTH  = 3'd4
   } csr_index_type;

   // Phases in the order in which they are numbered.
   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE        = 5'd0,
      PH_VIS_INGEST  = 5'd1,
      PH_PATCH_EMBED = 5'd2,
      PH_VIS_PROJ    = 5'd3,
      PH_SPATIAL_ATT = 5'd4,
      PH_VIS_FFN     = 5'd5,
      PH_PROJECTOR   = 5'd6,
      PH_CONCAT      = 5'd7,
      PH_PRE_PROJ    = 5'd8,
      PH_PRE_ATT     = 5'd9,
      PH_PRE_FFN     = 5'd10,
      PH_DEC_PROJ    = 5'd11,
      PH_CACHED_ATT  = 5'd12,
      PH_DEC_FFN     = 5'd13,
      PH_HEAD        = 5'd14,
      PH_DEQUANT     = 5'd15,
      PH_INV_XFORM   = 5'd16,
      PH_ACTUATE     = 5'd17
   } phase_type;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic [ADDR_W-1:0]  intercept_base;
      logic [LAYER_W-1:0] vision_layers;
      logic [LAYER_W-1:0] language_layers;
      logic [RUNS_W-1:0]  max_runs;
      logic [ILEN_W-1:0]  initial_length;
   } cfg_type;

   // Commands from the access decoder to the phase machine.
   typedef struct packed {
      logic advance;
      logic coin;
      logic clear_exit;
   } fsm_ctrl_type;

   // State that the access decoder reports back on the bus.
   typedef struct packed {
      phase_type        phase;
      logic [SEQ_W-1:0] seq_length;
      logic             exit_pending;
   } fsm_status_type;

endpackage

>>> rtl/core/lps_req_if.sv
// Request channel of the layered phase sequencer: one bus access per word.
// Depends on lps_pkg for the field widths.
interface lps_req_if;
   logic                          valid;
   logic                          ready;
   logic [lps_pkg::ADDR_W-1:0]    address;
   logic [1:0]                    action;
   logic                          coin;

   modport source (output valid, output address, output action, output coin, input ready);
   modport sink   (input valid, input address, input action, input coin, output ready);
endinterface

>>> rtl/core/lps_rsp_if.sv
// Response channel of the layered phase sequencer: read data or write acknowledge.
// Depends on lps_pkg for the field widths.
interface lps_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              is_ack;
   logic signed [lps_pkg::DATA_W-1:0] read_data;

   modport source (output valid, output is_ack, output read_data, input ready);
   modport sink   (input valid, input is_ack, input read_data, output ready);
endinterface

>>> rtl/core/lps_csr.sv
// Configuration registers of the layered phase sequencer.
// Depends on lps_pkg for register indexes, reset values and the cfg_type struct.
module lps_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [lps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lps_pkg::ADDR_W-1:0]        csr_write_data,
   output lps_pkg::cfg_type                  cfg
);

   lps_pkg::cfg_type cfg_ff;
   lps_pkg::cfg_type cfg_in;

   // Decode the write; an index beyond the list changes nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (lps_pkg::csr_index_type'(csr_index))
            lps_pkg::CSR_INTERCEPT_BASE:
               cfg_in.intercept_base = csr_write_data;
            lps_pkg::CSR_VISION_LAYERS:
               cfg_in.vision_layers = csr_write_data[lps_pkg::LAYER_W-1:0];
            lps_pkg::CSR_LANGUAGE_LAYERS:
               cfg_in.language_layers = csr_write_data[lps_pkg::LAYER_W-1:0];
            lps_pkg::CSR_MAX_RUNS:
               cfg_in.max_runs = csr_write_data[lps_pkg::RUNS_W-1:0];
            lps_pkg::CSR_INITIAL_LENGTH:
               cfg_in.initial_length = csr_write_data[lps_pkg::ILEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Register bank with its reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.intercept_base  <= lps_pkg::BASE_RESET;
         cfg_ff.vision_layers   <= lps_pkg::VISION_RESET;
         cfg_ff.language_layers <= lps_pkg::LANGUAGE_RESET;
         cfg_ff.max_runs        <= lps_pkg::MAX_RUNS_RESET;
         cfg_ff.initial_length  <= lps_pkg::INIT_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/lps_phase_fsm.sv
// Phase machine of the layered phase sequencer: phase, layer counters,
// sequence length, completed runs and the exit flag.
// Depends on lps_pkg for phase codes, limits and the control and status structs.
module lps_phase_fsm (
   input  logic                     clock,
   input  logic                     reset,
   input  lps_pkg::cfg_type         cfg,
   input  lps_pkg::fsm_ctrl_type    ctrl,
   output lps_pkg::fsm_status_type  status
);

   lps_pkg::phase_type                phase_ff, phase_in;
   logic [lps_pkg::LAYER_W-1:0]       vision_count_ff, vision_count_in;
   logic [lps_pkg::LAYER_W-1:0]       prefill_count_ff, prefill_count_in;
   logic [lps_pkg::LAYER_W-1:0]       decode_count_ff, decode_count_in;
   logic [lps_pkg::SEQ_W-1:0]         seq_length_ff, seq_length_in;
   logic [lps_pkg::RUNS_W-1:0]        runs_done_ff, runs_done_in;
   logic                              exit_pending_ff, exit_pending_in;

   logic [lps_pkg::LAYER_W-1:0]       vision_bump;
   logic [lps_pkg::LAYER_W-1:0]       prefill_bump;
   logic [lps_pkg::LAYER_W-1:0]       decode_bump;
   logic [lps_pkg::RUNS_W-1:0]        runs_bump;

   // Saturating increments of the counters.
   assign vision_bump  = (vision_count_ff == lps_pkg::LAYER_MAX) ? vision_count_ff
                                                                 : vision_count_ff + 1'b1;
   assign prefill_bump = (prefill_count_ff == lps_pkg::LAYER_MAX) ? prefill_count_ff
                                                                   : prefill_count_ff + 1'b1;
   assign decode_bump  = (decode_count_ff == lps_pkg::LAYER_MAX) ? decode_count_ff
                                                                 : decode_count_ff + 1'b1;
   assign runs_bump    = (runs_done_ff == lps_pkg::RUNS_MAX) ? runs_done_ff
                                                            : runs_done_ff + 1'b1;

   // Next phase and counter updates on an advance access.
   always_comb begin
      phase_in         = phase_ff;
      vision_count_in  = vision_count_ff;
      prefill_count_in = prefill_count_ff;
      decode_count_in  = decode_count_ff;
      seq_length_in    = seq_length_ff;
      runs_done_in     = runs_done_ff;
      exit_pending_in  = exit_pending_ff;

      // A phase read that reports the exit word clears the flag.
      if (ctrl.clear_exit) begin
         exit_pending_in = 1'b0;
      end

      if (ctrl.advance) begin
         unique case (phase_ff)
            lps_pkg::PH_IDLE:        phase_in = lps_pkg::PH_VIS_INGEST;
            lps_pkg::PH_VIS_INGEST:  phase_in = lps_pkg::PH_PATCH_EMBED;
            lps_pkg::PH_PATCH_EMBED: phase_in = lps_pkg::PH_VIS_PROJ;
            lps_pkg::PH_VIS_PROJ:    phase_in = lps_pkg::PH_SPATIAL_ATT;
            lps_pkg::PH_SPATIAL_ATT: phase_in = lps_pkg::PH_VIS_FFN;
            lps_pkg::PH_VIS_FFN: begin
               vision_count_in = vision_bump;
               phase_in = (vision_bump < cfg.vision_layers) ? lps_pkg::PH_VIS_PROJ
                                                            : lps_pkg::PH_PROJECTOR;
            end
            lps_pkg::PH_PROJECTOR:   phase_in = lps_pkg::PH_CONCAT;
            lps_pkg::PH_CONCAT: begin
               seq_length_in = lps_pkg::SEQ_W'(cfg.initial_length);
               phase_in      = lps_pkg::PH_PRE_PROJ;
            end
            lps_pkg::PH_PRE_PROJ:    phase_in = lps_pkg::PH_PRE_ATT;
            lps_pkg::PH_PRE_ATT:     phase_in = lps_pkg::PH_PRE_FFN;
            lps_pkg::PH_PRE_FFN: begin
               prefill_count_in = prefill_bump;
               phase_in = (prefill_bump < cfg.language_layers) ? lps_pkg::PH_PRE_PROJ
                                                               : lps_pkg::PH_DEC_PROJ;
            end
            lps_pkg::PH_DEC_PROJ:    phase_in = lps_pkg::PH_CACHED_ATT;
            lps_pkg::PH_CACHED_ATT:  phase_in = lps_pkg::PH_DEC_FFN;
            lps_pkg::PH_DEC_FFN: begin
               // The decode layer count restarts once a token is finished.
               if (decode_bump < cfg.language_layers) begin
                  decode_count_in = decode_bump;
                  phase_in        = lps_pkg::PH_DEC_PROJ;
               end else begin
                  decode_count_in = '0;
                  phase_in        = lps_pkg::PH_HEAD;
               end
            end
            lps_pkg::PH_HEAD: begin
               // A set coin decodes one more token and lengthens the sequence.
               if (ctrl.coin) begin
                  if (seq_length_ff != lps_pkg::SEQ_MAX) begin
                     seq_length_in = seq_length_ff + 1'b1;
                  end
                  decode_count_in = '0;
                  phase_in        = lps_pkg::PH_DEC_PROJ;
               end else begin
                  phase_in = lps_pkg::PH_DEQUANT;
               end
            end
            lps_pkg::PH_DEQUANT:     phase_in = lps_pkg::PH_INV_XFORM;
            lps_pkg::PH_INV_XFORM:   phase_in = lps_pkg::PH_ACTUATE;
            lps_pkg::PH_ACTUATE: begin
               phase_in         = lps_pkg::PH_IDLE;
               vision_count_in  = '0;
               prefill_count_in = '0;
               decode_count_in  = '0;
               runs_done_in     = runs_bump;
               if ((cfg.max_runs != '0) && (runs_bump >= cfg.max_runs)) begin
                  exit_pending_in = 1'b1;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= lps_pkg::PH_IDLE;
         vision_count_ff  <= '0;
         prefill_count_ff <= '0;
         decode_count_ff  <= '0;
         seq_length_ff    <= '0;
         runs_done_ff     <= '0;
         exit_pending_ff  <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         vision_count_ff  <= vision_count_in;
         prefill_count_ff <= prefill_count_in;
         decode_count_ff  <= decode_count_in;
         seq_length_ff    <= seq_length_in;
         runs_done_ff     <= runs_done_in;
         exit_pending_ff  <= exit_pending_in;
      end
   end

   assign status.phase        = phase_ff;
   assign status.seq_length   = seq_length_ff;
   assign status.exit_pending = exit_pending_ff;

endmodule

>>> rtl/core/layered_phase_sequencer.sv
// Top level of the layered phase sequencer: access register, offset decode,
// response register, configuration bank and phase machine.
// Depends on lps_pkg, lps_req_if, lps_rsp_if, lps_csr and lps_phase_fsm.
//
// The block takes one bus access word per clock cycle unless it stalls. A word is
// held in the access register, where the offset is formed and decoded, and the
// phase machine is updated as the word leaves that register; a response, if the
// access has one, appears in the response register on the next cycle. The
// response register lets a new word enter while an earlier response is still
// waiting, and the block stalls only when that register is full and not being
// taken. Phase reads at offset 0, length reads at offset 8 and advances at
// offset 4 give one response each; every other access is absorbed silently.
// Configuration is written through the csr_ port and takes effect on the next
// cycle.
module layered_phase_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   lps_req_if.sink                       req_chan,
   lps_rsp_if.source                     rsp_chan,
   input  logic                          csr_write_enable,
   input  logic [lps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lps_pkg::ADDR_W-1:0]    csr_write_data
);

   lps_pkg::cfg_type        cfg;
   lps_pkg::fsm_ctrl_type   fsm_ctrl;
   lps_pkg::fsm_status_type fsm_status;

   // Access register.
   logic                           acc_valid_ff, acc_valid_in;
   logic [lps_pkg::ADDR_W-1:0]     acc_address_ff;
   lps_pkg::action_type            acc_action_ff;
   logic                           acc_coin_ff;

   // Response register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_is_ack_ff, rsp_is_ack_in;
   logic [lps_pkg::DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [lps_pkg::ADDR_W-1:0]     offset;
   logic                           is_phase_read;
   logic                           is_length_read;
   logic                           is_advance;
   logic                           acc_fire;
   logic                           req_take;

   lps_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   lps_phase_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .ctrl   (fsm_ctrl),
      .status (fsm_status)
   );

   // The access register drains whenever the response register can take a word.
   assign acc_fire       = acc_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !acc_valid_ff || acc_fire;
   assign req_take       = req_chan.valid && req_chan.ready;

   // Offset decode of the held access.
   assign offset         = acc_address_ff - cfg.intercept_base;
   assign is_phase_read  = (offset == lps_pkg::PHASE_OFFSET)
                           && (acc_action_ff == lps_pkg::ACT_SHARED_READ);
   assign is_length_read = (offset == lps_pkg::LENGTH_OFFSET)
                           && (acc_action_ff == lps_pkg::ACT_SHARED_READ);
   assign is_advance     = (offset == lps_pkg::ADVANCE_OFFSET)
                           && ((acc_action_ff == lps_pkg::ACT_WRITE)
                               || (acc_action_ff == lps_pkg::ACT_EXCL_READ));

   // Commands to the phase machine, applied as the access leaves its register.
   assign fsm_ctrl.advance    = acc_fire && is_advance;
   assign fsm_ctrl.coin       = acc_coin_ff;
   assign fsm_ctrl.clear_exit = acc_fire && is_phase_read && fsm_status.exit_pending;

   // Access register control.
   always_comb begin
      acc_valid_in = acc_valid_ff;
      if (req_take) begin
         acc_valid_in = 1'b1;
      end else if (acc_fire) begin
         acc_valid_in = 1'b0;
      end
   end

   // Response word and response register control.
   always_comb begin
      rsp_is_ack_in = rsp_is_ack_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      if (acc_fire && (is_phase_read || is_length_read || is_advance)) begin
         rsp_valid_in  = 1'b1;
         rsp_is_ack_in = is_advance;
         if (is_advance) begin
            rsp_data_in = '0;
         end else if (is_length_read) begin
            rsp_data_in = lps_pkg::DATA_W'(fsm_status.seq_length);
         end else if (fsm_status.exit_pending) begin
            rsp_data_in = lps_pkg::EXIT_WORD;
         end else begin
            rsp_data_in = lps_pkg::DATA_W'(fsm_status.phase);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_valid_ff <= acc_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         acc_address_ff <= req_chan.address;
         acc_action_ff  <= lps_pkg::action_type'(req_chan.action);
         acc_coin_ff    <= req_chan.coin;
      end
      rsp_is_ack_ff <= rsp_is_ack_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.is_ack    = rsp_is_ack_ff;
   assign rsp_chan.read_data = $signed(rsp_data_ff);

endmodule
